/* rtl/sdeq_pkg.sv */
// shared types and codes for the searchable double-ended queue
package sdeq_pkg;

  localparam int VAL_W  = 32;
  localparam int CMD_W  = 3;
  localparam int ERR_W  = 2;
  localparam int OCC_W  = 5;
  localparam int OUT_W  = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_FIND       = 3'd5
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // what every cell does with its word this cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHR,
    OP_SHL,
    OP_APPEND,
    OP_REMOVE
  } cell_op_t;

  // first member sits in the top bits, so popped_value ends up in the lowest bits
  typedef struct packed {
    logic [OCC_W-1:0] occupancy;
    err_t             error_code;
    logic             hit;
    logic [VAL_W-1:0] popped_value;
  } result_t;

endpackage

/* rtl/sdeq_cell.sv */
// one storage cell of the queue chain: holds a word, compares it, takes a neighbor's word
module sdeq_cell #(
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 5,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  sdeq_pkg::cell_op_t   op,
  input  logic [WORD_BITS-1:0] key,
  input  logic [CNT_W-1:0]     count,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  input  logic                 seen_in,
  output logic [WORD_BITS-1:0] word,
  output logic                 seen_out
);
  import sdeq_pkg::*;

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;
  logic                 occupied;
  logic                 match;

  assign occupied = count > CNT_W'(IDX);
  assign match    = occupied && (word_r == key);
  // set from the first matching cell onward
  assign seen_out = seen_in | match;
  assign word     = word_r;

  always_comb begin
    word_nxt = word_r;
    case (op)
      OP_SHR:    word_nxt = left_word;
      OP_SHL:    word_nxt = right_word;
      OP_APPEND: begin
        if (count == CNT_W'(IDX)) word_nxt = key;
      end
      OP_REMOVE: begin
        if (seen_out) word_nxt = right_word;
      end
      default:   word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

/* rtl/searchable_double_ended_queue_unit.sv */
// top level of the searchable double-ended queue: command decode, cell chain, result register
//
//  channel | ports                         | payload
//  --------+-------------------------------+------------------------------------------
//  in      | in_tvalid in_tready           | tdata item_value, tuser cmd
//  out     | out_tvalid out_tready         | tdata popped_value hit error_code occupancy
//
// every command completes as it is accepted: all cells compare and shift in parallel,
// with the match found along the cell chain; the result lands in the output register
// a word is taken whenever the output register is empty or is being drained
// reset clears the entry count and the output valid; cell words need no reset
// a stalled output holds its word and holds off the input
module searchable_double_ended_queue_unit #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sdeq_pkg::VAL_W-1:0]  in_tdata,   // [31:0] item_value
  input  logic [sdeq_pkg::CMD_W-1:0]  in_tuser,   // [2:0] cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sdeq_pkg::OUT_W-1:0]  out_tdata   // [31:0] popped_value, [32] hit,
                                                  // [34:33] error_code, [39:35] occupancy
);
  import sdeq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  result_t              res_r;
  result_t              res_nxt;

  logic                 accept;
  logic                 full;
  logic                 empty;
  cell_op_t             op;
  logic [WORD_BITS-1:0] key;
  logic [WORD_BITS-1:0] cell_word [DEPTH];
  logic [DEPTH:0]       seen;
  logic [IDX_W-1:0]     tail_idx;
  logic [WORD_BITS-1:0] popped_word;
  logic [VAL_W-1:0]     popped_ext;
  logic [OCC_W-1:0]     occ_ext;
  cmd_t                 cmd;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;
  assign cmd        = cmd_t'(in_tuser);
  assign full       = count_r == CNT_W'(DEPTH);
  assign empty      = count_r == '0;
  assign tail_idx   = IDX_W'(count_r - CNT_W'(1));

  // item_value is taken modulo 2^WORD_BITS, the popped word is zero-extended
  assign key        = WORD_BITS'(in_tdata);
  assign popped_ext = VAL_W'(popped_word);

  if (CNT_W >= OCC_W) begin : g_occ_trunc
    assign occ_ext = count_nxt[OCC_W-1:0];
  end else begin : g_occ_ext
    assign occ_ext = {{(OCC_W - CNT_W){1'b0}}, count_nxt};
  end

  // command decode into one cell operation
  always_comb begin
    op = OP_HOLD;
    if (accept) begin
      case (cmd)
        CMD_PUSH_FRONT: if (!full) op = OP_SHR;
        CMD_PUSH_BACK:  if (!full) op = OP_APPEND;
        CMD_POP_FRONT:  if (!empty) op = OP_SHL;
        CMD_REMOVE:     op = OP_REMOVE;
        default:        op = OP_HOLD;
      endcase
    end
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = key;
    end else begin : g_mid
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_word[i+1];
    end
    sdeq_cell #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .key        (key),
      .count      (count_r),
      .left_word  (left_w),
      .right_word (right_w),
      .seen_in    (seen[i]),
      .word       (cell_word[i]),
      .seen_out   (seen[i+1])
    );
  end

  always_comb begin
    count_nxt   = count_r;
    popped_word = '0;
    res_nxt     = res_r;
    res_nxt.hit = 1'b0;
    res_nxt.error_code = ERR_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) res_nxt.error_code = ERR_FULL;
        else      count_nxt = count_r + CNT_W'(1);
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          res_nxt.error_code = ERR_EMPTY;
        end else begin
          popped_word = cell_word[0];
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          res_nxt.error_code = ERR_EMPTY;
        end else begin
          popped_word = cell_word[tail_idx];
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        res_nxt.hit = seen[DEPTH];
        if (seen[DEPTH]) count_nxt = count_r - CNT_W'(1);
      end
      CMD_FIND:   res_nxt.hit = seen[DEPTH];
      default:    count_nxt = count_r;
    endcase
    res_nxt.popped_value = popped_ext;
    res_nxt.occupancy    = occ_ext;
    if (!accept) begin
      count_nxt = count_r;
      res_nxt   = res_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept)          out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

/* test/searchable_double_ended_queue_unit_tb.sv */
// self-checking testbench for the searchable double-ended queue unit
`timescale 1ns / 100ps

module searchable_double_ended_queue_unit_tb;
  import sdeq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 1450;
  localparam int CALM_TAIL   = 120;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_WAIT  = 8;

  // spare command codes: no operation, result carries only the occupancy
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  // how a stretch of random commands leans
  localparam int LEAN_FILL  = 0;
  localparam int LEAN_DRAIN = 1;
  localparam int LEAN_MIXED = 2;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [VAL_W-1:0] word;
  } deque_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [VAL_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  deque_cmd_t pending_cmds[$];
  result_t expected_results[$];
  logic [VAL_W-1:0] shadow_words[$];

  int total_cmds = 0;
  int accepted_cmds = 0;
  int results_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  logic calm_phase = 1'b0;
  logic hold_off = 1'b0;

  int refused_pushes = 0;
  int empty_pops = 0;
  int search_hits = 0;
  int peak_fill = 0;

  searchable_double_ended_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  // shadow deque: applies one command and returns what the block should report
  function automatic result_t deque_apply(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] word);
    result_t r;
    int idx;
    r = '0;
    r.error_code = ERR_OK;
    idx = -1;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_words.size() >= DEPTH) begin
          r.error_code = ERR_FULL;
          refused_pushes++;
        end else if (op == CMD_PUSH_FRONT) begin
          shadow_words.push_front(word);
        end else begin
          shadow_words.push_back(word);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_words.size() == 0) begin
          r.error_code = ERR_EMPTY;
          empty_pops++;
        end else if (op == CMD_POP_FRONT) begin
          r.popped_value = shadow_words.pop_front();
        end else begin
          r.popped_value = shadow_words.pop_back();
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        // first match counted from the front
        for (int i = 0; i < shadow_words.size(); i++)
          if (idx < 0 && shadow_words[i] == word) idx = i;
        if (idx >= 0) begin
          r.hit = 1'b1;
          search_hits++;
          if (op == CMD_REMOVE) shadow_words.delete(idx);
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(shadow_words.size());
    if (shadow_words.size() > peak_fill) peak_fill = shadow_words.size();
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 7);
      6: return 32'hffff_ffff - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int lean);
    int roll;
    roll = $urandom_range(0, 15);
    if (lean == LEAN_FILL) begin
      if (roll < 12) return (roll[0]) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      return (roll[0]) ? CMD_FIND : CMD_REMOVE;
    end
    if (lean == LEAN_DRAIN) begin
      if (roll < 11) return (roll[0]) ? CMD_POP_FRONT : CMD_POP_BACK;
      if (roll < 14) return CMD_REMOVE;
      return CMD_FIND;
    end
    case (roll)
      0, 1:    return CMD_PUSH_FRONT;
      2, 3:    return CMD_PUSH_BACK;
      4, 5:    return CMD_POP_FRONT;
      6, 7:    return CMD_POP_BACK;
      8, 9, 10: return CMD_REMOVE;
      11, 12, 13: return CMD_FIND;
      14:      return CMD_SPARE_A;
      default: return CMD_SPARE_B;
    endcase
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] word);
    deque_cmd_t c;
    c.op = op;
    c.word = word;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on result %0d, %s: expected %h, got %h",
                 results_seen, name, want, got);
    end
  endtask

  // driver: offers the head of the pending list, records the prediction on acceptance
  always @(posedge clk) begin : drive_cmds
    logic next_valid;
    next_valid = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(deque_apply(in_tuser, in_tdata));
        void'(pending_cmds.pop_front());
        accepted_cmds <= accepted_cmds + 1;
      end
      if (in_tvalid && !in_tready) begin
        next_valid = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (pending_cmds.size() > 0) begin
        if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 17) - 1;
        else
          next_valid = 1'b1;
      end
      calm_phase <= (pending_cmds.size() <= CALM_TAIL);
      if (next_valid && !(in_tvalid && !in_tready)) begin
        in_tuser <= pending_cmds[0].op;
        in_tdata <= pending_cmds[0].word;
      end
      in_tvalid <= next_valid;
    end
  end

  // monitor: checks every result word against the oldest prediction, drives backpressure
  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got.popped_value = out_tdata[31:0];
        got.hit          = out_tdata[32];
        got.error_code   = err_t'(out_tdata[34:33]);
        got.occupancy    = out_tdata[39:35];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result word with nothing pending: %h", out_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("popped_value", want.popped_value, got.popped_value);
          check_field("hit", VAL_W'(want.hit), VAL_W'(got.hit));
          check_field("error_code", VAL_W'(want.error_code), VAL_W'(got.error_code));
          check_field("occupancy", VAL_W'(want.occupancy), VAL_W'(got.occupancy));
        end
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 17) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // long receiver stall while the sender keeps offering, so the input backs up
  initial begin : long_stall
    @(posedge clk);
    while (accepted_cmds < HOLD_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : run
    int n;
    int lean;
    // empty store: both pops fail, searches miss; then a push at each end, finds and spare codes
    queue_cmd(CMD_POP_FRONT, 32'h0);
    queue_cmd(CMD_POP_BACK, 32'h0);
    queue_cmd(CMD_FIND, 32'h0);
    queue_cmd(CMD_REMOVE, 32'hffff_ffff);
    queue_cmd(CMD_PUSH_FRONT, 32'h0);
    queue_cmd(CMD_PUSH_BACK, 32'hffff_ffff);
    queue_cmd(CMD_FIND, 32'hffff_ffff);
    queue_cmd(CMD_FIND, 32'h1);
    queue_cmd(CMD_SPARE_A, 32'hffff_ffff);
    queue_cmd(CMD_SPARE_B, 32'h0);
    // duplicates: remove takes the front-most one and closes the gap
    queue_cmd(CMD_PUSH_BACK, 32'h5);
    queue_cmd(CMD_PUSH_FRONT, 32'h5);
    queue_cmd(CMD_REMOVE, 32'h5);
    queue_cmd(CMD_FIND, 32'h5);
    queue_cmd(CMD_REMOVE, 32'h5);
    queue_cmd(CMD_REMOVE, 32'h5);
    queue_cmd(CMD_REMOVE, 32'h1234_5678);
    queue_cmd(CMD_POP_BACK, 32'h0);
    queue_cmd(CMD_POP_FRONT, 32'h0);
    queue_cmd(CMD_POP_FRONT, 32'h0);
    // random stretches: fill past full, drain past empty, or mix
    while (pending_cmds.size() < RAND_ITEMS) begin
      lean = $urandom_range(0, 3);
      if (lean > LEAN_MIXED) lean = LEAN_MIXED;
      n = (lean == LEAN_MIXED) ? $urandom_range(10, 30) : $urandom_range(18, 24);
      repeat (n) queue_cmd(pick_cmd(lean), pick_word());
    end
    total_cmds = pending_cmds.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cmds < total_cmds || results_seen < total_cmds) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", expected_results.size());
    end
    $display("ran %0d commands: %0d refused pushes, %0d empty pops, %0d search hits",
             total_cmds, refused_pushes, empty_pops, search_hits);
    $display("peak occupancy %0d of %0d, one long output stall, %0d failures",
             peak_fill, DEPTH, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
